// ----- rtl/csc_pkg.sv -----
// csc_pkg: shared sizes, function codes, table entry layout, table command, search key
// and controller states for the callsign suffix cache; depends on nothing
package csc_pkg;

   // table geometry
   localparam int ENTRIES    = 128;
   localparam int NAME_CHARS = 6;
   localparam int NAME_W     = 8 * NAME_CHARS;
   localparam int SLOT_W     = $clog2(ENTRIES);
   localparam int SSID_W     = 8;
   localparam int STAMP_W    = 32;

   // request function codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // one table entry
   typedef struct packed {
      logic [NAME_W-1:0]  name;
      logic [SSID_W-1:0]  ssid;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   // command from the controller to the table memory
   typedef struct packed {
      logic              rd;
      logic              wr;
      logic [SLOT_W-1:0] addr;
      entry_type         wdata;
   } tbl_cmd_type;

   // search key and its lookup validity
   typedef struct packed {
      logic [NAME_W-1:0] key;
      logic              ok;
   } key_info_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/callsign_ssid_cache_top.sv -----
// callsign_ssid_cache_top: top level of the callsign suffix cache
// depends on csc_pkg, csc_key_norm, csc_table_mem, csc_scan_ctrl
//
// Fully associative cache of csc_pkg::ENTRIES names (128), each with an 8-bit
// suffix and an age stamp, held in one single-port memory. Every request walks
// the whole table through that one read port, one entry per cycle. An insert
// adds a write-back step after the scan. One request is in work at a time, and
// req_ready is high only while the block is idle; after each result the block
// returns to idle before it takes the next request. The result sits in an
// output register, and a finished request waits there for rsp_ready. Insert
// reuses the first exact name match, else the first empty slot, else the first
// slot with the oldest stamp. Lookups need a 1 to 6 character alphanumeric
// name, folded to uppercase. The table is empty right after reset; no clearing
// pass.
module callsign_ssid_cache_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_func,
   input  logic [csc_pkg::NAME_W-1:0]   req_name,
   input  logic                         req_name_too_long,
   input  logic [csc_pkg::SSID_W-1:0]   req_suffix_in,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic [csc_pkg::SSID_W-1:0]   rsp_ssid_out,
   output logic [csc_pkg::SLOT_W-1:0]   rsp_slot
);

   csc_pkg::key_info_type key_info;
   csc_pkg::tbl_cmd_type  tbl_cmd;
   csc_pkg::entry_type    rd_entry;

   // search key from the request name
   csc_key_norm u_key_norm (
      .func          (req_func),
      .name          (req_name),
      .name_too_long (req_name_too_long),
      .key_info      (key_info)
   );

   // entry table
   csc_table_mem u_table_mem (
      .clock    (clock),
      .reset    (reset),
      .tbl_cmd  (tbl_cmd),
      .rd_entry (rd_entry)
   );

   // scan sequencer and result register
   csc_scan_ctrl u_scan_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_suffix_in (req_suffix_in),
      .key_info      (key_info),
      .tbl_cmd       (tbl_cmd),
      .rd_entry      (rd_entry),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hit       (rsp_hit),
      .rsp_ssid_out  (rsp_ssid_out),
      .rsp_slot      (rsp_slot)
   );

endmodule

// ----- rtl/csc_key_norm.sv -----
// csc_key_norm: cleans up the offered name into a search key (zero after first
// nul, uppercase fold for lookups) and checks lookup validity; uses csc_pkg
module csc_key_norm (
   input  logic                        func,
   input  logic [csc_pkg::NAME_W-1:0]  name,
   input  logic                        name_too_long,
   output csc_pkg::key_info_type       key_info
);

   logic [csc_pkg::NAME_W-1:0] raw_key;
   logic [csc_pkg::NAME_W-1:0] fold_key;
   logic                       all_alnum;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= 8'h41) && (c <= 8'h5A);
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return (c >= 8'h61) && (c <= 8'h7A);
   endfunction

   // per character: clear after the first nul, check class, fold case
   always_comb begin
      logic       ended;
      logic [7:0] c;
      ended     = 1'b0;
      all_alnum = 1'b1;
      raw_key   = '0;
      fold_key  = '0;
      for (int i = 0; i < csc_pkg::NAME_CHARS; i++) begin
         c = name[csc_pkg::NAME_W-1-8*i -: 8];
         if (c == 8'h00) begin
            ended = 1'b1;
         end
         if (ended) begin
            c = 8'h00;
         end else if (!(is_digit(c) || is_upper(c) || is_lower(c))) begin
            all_alnum = 1'b0;
         end
         raw_key[csc_pkg::NAME_W-1-8*i -: 8]  = c;
         fold_key[csc_pkg::NAME_W-1-8*i -: 8] = is_lower(c) ? (c & 8'hDF) : c;
      end
   end

   // inserts store the name as given, lookups search the folded form
   assign key_info.key = (func == csc_pkg::FUNC_LOOKUP) ? fold_key : raw_key;
   assign key_info.ok  = (name[csc_pkg::NAME_W-1 -: 8] != 8'h00) && !name_too_long &&
                         all_alnum;

endmodule

// ----- rtl/csc_table_mem.sv -----
// csc_table_mem: single-port entry memory with registered read data and per-entry
// valid flags so that unwritten entries read as empty; uses csc_pkg
module csc_table_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  csc_pkg::tbl_cmd_type  tbl_cmd,
   output csc_pkg::entry_type    rd_entry
);

   csc_pkg::entry_type mem [csc_pkg::ENTRIES];
   logic [csc_pkg::ENTRIES-1:0] valid_ff;
   logic [csc_pkg::ENTRIES-1:0] valid_in;
   csc_pkg::entry_type          rd_data_ff;
   logic                        rd_valid_ff;

   // valid flag set on every write
   always_comb begin
      valid_in = valid_ff;
      if (tbl_cmd.wr) begin
         valid_in[tbl_cmd.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // memory array, one access per cycle
   always_ff @(posedge clock) begin
      if (tbl_cmd.wr) begin
         mem[tbl_cmd.addr] <= tbl_cmd.wdata;
      end
      if (tbl_cmd.rd) begin
         rd_data_ff  <= mem[tbl_cmd.addr];
         rd_valid_ff <= valid_ff[tbl_cmd.addr];
      end
   end

   // an entry never written reads as all zero
   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ----- rtl/csc_scan_ctrl.sv -----
// csc_scan_ctrl: request capture, table scan sequencer, victim choice, write-back
// and result register; uses csc_pkg
module csc_scan_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_func,
   input  logic [csc_pkg::SSID_W-1:0]   req_suffix_in,
   input  csc_pkg::key_info_type        key_info,
   output csc_pkg::tbl_cmd_type         tbl_cmd,
   input  csc_pkg::entry_type           rd_entry,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic [csc_pkg::SSID_W-1:0]   rsp_ssid_out,
   output logic [csc_pkg::SLOT_W-1:0]   rsp_slot
);

   localparam logic [csc_pkg::SLOT_W-1:0] LAST_IDX = csc_pkg::SLOT_W'(csc_pkg::ENTRIES - 1);

   csc_pkg::state_type state_ff, state_in;

   // captured request
   logic                          func_ff, func_in;
   logic [csc_pkg::NAME_W-1:0]    key_ff, key_in;
   logic                          ok_ff, ok_in;
   logic [csc_pkg::SSID_W-1:0]    suffix_ff, suffix_in;

   // scan address and read-data alignment
   logic [csc_pkg::SLOT_W-1:0]    cnt_ff, cnt_in;
   logic                          chk_ff, chk_in;
   logic [csc_pkg::SLOT_W-1:0]    chk_idx_ff, chk_idx_in;

   // scan trackers
   logic                          match_ff, match_in;
   logic [csc_pkg::SLOT_W-1:0]    match_idx_ff, match_idx_in;
   logic [csc_pkg::SSID_W-1:0]    match_ssid_ff, match_ssid_in;
   logic                          empty_ff, empty_in;
   logic [csc_pkg::SLOT_W-1:0]    empty_idx_ff, empty_idx_in;
   logic [csc_pkg::SLOT_W-1:0]    old_idx_ff, old_idx_in;
   logic [csc_pkg::STAMP_W-1:0]   old_stamp_ff, old_stamp_in;

   // age counter
   logic [csc_pkg::STAMP_W-1:0]   stamp_ff, stamp_in;
   logic [csc_pkg::STAMP_W-1:0]   next_stamp;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_hit_ff, rsp_hit_in;
   logic [csc_pkg::SSID_W-1:0]    rsp_ssid_ff, rsp_ssid_in;
   logic [csc_pkg::SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;

   logic                          accept;
   logic                          rsp_free;
   logic                          rsp_load;
   logic [csc_pkg::SLOT_W-1:0]    target;
   logic                          lookup_hit;

   assign accept     = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign next_stamp = stamp_ff + csc_pkg::STAMP_W'(1);
   assign lookup_hit = ok_ff && match_ff;

   // insert target: reused match, else first empty, else oldest
   always_comb begin
      priority if (match_ff) begin
         target = match_idx_ff;
      end else if (empty_ff) begin
         target = empty_idx_ff;
      end else begin
         target = old_idx_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = csc_pkg::ST_SCAN;
            end
         end
         csc_pkg::ST_SCAN: begin
            if (cnt_ff == LAST_IDX) begin
               state_in = csc_pkg::ST_LAST;
            end
         end
         csc_pkg::ST_LAST: begin
            state_in = (func_ff == csc_pkg::FUNC_INSERT) ? csc_pkg::ST_WRITE :
                                                           csc_pkg::ST_DONE;
         end
         csc_pkg::ST_WRITE: begin
            state_in = csc_pkg::ST_DONE;
         end
         csc_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = csc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = csc_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs: handshake, table command, result load
   always_comb begin
      req_ready           = 1'b0;
      rsp_load            = 1'b0;
      tbl_cmd.rd          = 1'b0;
      tbl_cmd.wr          = 1'b0;
      tbl_cmd.addr        = cnt_ff;
      tbl_cmd.wdata.name  = key_ff;
      tbl_cmd.wdata.ssid  = suffix_ff;
      tbl_cmd.wdata.stamp = next_stamp;
      unique case (state_ff)
         csc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         csc_pkg::ST_SCAN: begin
            tbl_cmd.rd = 1'b1;
         end
         csc_pkg::ST_LAST: begin
         end
         csc_pkg::ST_WRITE: begin
            tbl_cmd.wr   = 1'b1;
            tbl_cmd.addr = target;
         end
         csc_pkg::ST_DONE: begin
            rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      func_in       = func_ff;
      key_in        = key_ff;
      ok_in         = ok_ff;
      suffix_in     = suffix_ff;
      cnt_in        = cnt_ff;
      chk_in        = tbl_cmd.rd;
      chk_idx_in    = tbl_cmd.addr;
      match_in      = match_ff;
      match_idx_in  = match_idx_ff;
      match_ssid_in = match_ssid_ff;
      empty_in      = empty_ff;
      empty_idx_in  = empty_idx_ff;
      old_idx_in    = old_idx_ff;
      old_stamp_in  = old_stamp_ff;
      stamp_in      = stamp_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_ssid_in   = rsp_ssid_ff;
      rsp_slot_in   = rsp_slot_ff;

      // capture the request and restart the scan
      if (accept) begin
         func_in   = req_func;
         key_in    = key_info.key;
         ok_in     = key_info.ok;
         suffix_in = req_suffix_in;
         cnt_in    = '0;
         match_in  = 1'b0;
         empty_in  = 1'b0;
      end

      // advance the read address
      if (tbl_cmd.rd) begin
         cnt_in = cnt_ff + csc_pkg::SLOT_W'(1);
      end

      // examine the entry read last cycle; stop tracking after the first match
      if (chk_ff && !match_ff) begin
         if (rd_entry.name == key_ff) begin
            match_in      = 1'b1;
            match_idx_in  = chk_idx_ff;
            match_ssid_in = rd_entry.ssid;
         end else begin
            if ((rd_entry.name == '0) && !empty_ff) begin
               empty_in     = 1'b1;
               empty_idx_in = chk_idx_ff;
            end
            if ((chk_idx_ff == '0) || (rd_entry.stamp < old_stamp_ff)) begin
               old_idx_in   = chk_idx_ff;
               old_stamp_in = rd_entry.stamp;
            end
         end
      end

      // age counter steps with every insert write
      if (tbl_cmd.wr) begin
         stamp_in = next_stamp;
      end

      // result register
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (func_ff == csc_pkg::FUNC_INSERT) begin
            rsp_hit_in  = match_ff;
            rsp_ssid_in = '0;
            rsp_slot_in = target;
         end else begin
            rsp_hit_in  = lookup_hit;
            rsp_ssid_in = lookup_hit ? match_ssid_ff : '0;
            rsp_slot_in = lookup_hit ? match_idx_ff : '0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csc_pkg::ST_IDLE;
         chk_ff       <= 1'b0;
         match_ff     <= 1'b0;
         empty_ff     <= 1'b0;
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_ff       <= chk_in;
         match_ff     <= match_in;
         empty_ff     <= empty_in;
         stamp_ff     <= stamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      ok_ff         <= ok_in;
      suffix_ff     <= suffix_in;
      cnt_ff        <= cnt_in;
      chk_idx_ff    <= chk_idx_in;
      match_idx_ff  <= match_idx_in;
      match_ssid_ff <= match_ssid_in;
      empty_idx_ff  <= empty_idx_in;
      old_idx_ff    <= old_idx_in;
      old_stamp_ff  <= old_stamp_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_ssid_ff   <= rsp_ssid_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_ssid_out = rsp_ssid_ff;
   assign rsp_slot     = rsp_slot_ff;

endmodule

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for callsign_ssid_cache_top, insert and lookup traffic
// against an in-bench model of the name table; depends on csc_pkg and the cache rtl
module tb_top;

   localparam int CLK_PERIOD   = 12;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1250;
   localparam int POOL_SIZE    = 150;
   localparam int QUIET_ITEMS  = 100;
   localparam int HOLD_CYCLES  = 1000;
   localparam int DRAIN_CYCLES = 200;
   localparam int LIMIT_CYCLES = 1_500_000;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic                       func;
      logic [csc_pkg::NAME_W-1:0] name;
      logic                       too_long;
      logic [csc_pkg::SSID_W-1:0] suffix;
   } cache_req_type;

   typedef struct {
      logic                       hit;
      logic [csc_pkg::SSID_W-1:0] ssid;
      logic [csc_pkg::SLOT_W-1:0] slot;
   } cache_rsp_type;

   logic                       clock             = 1'b0;
   logic                       reset             = 1'b1;
   logic                       req_valid         = 1'b0;
   logic                       req_ready;
   logic                       req_func          = csc_pkg::FUNC_INSERT;
   logic [csc_pkg::NAME_W-1:0] req_name          = '0;
   logic                       req_name_too_long = 1'b0;
   logic [csc_pkg::SSID_W-1:0] req_suffix_in     = '0;
   logic                       rsp_valid;
   logic                       rsp_ready         = 1'b0;
   logic                       rsp_hit;
   logic [csc_pkg::SSID_W-1:0] rsp_ssid_out;
   logic [csc_pkg::SLOT_W-1:0] rsp_slot;

   // model of the name table
   logic [csc_pkg::NAME_W-1:0]  tbl_name  [csc_pkg::ENTRIES] = '{default: '0};
   logic [csc_pkg::SSID_W-1:0]  tbl_ssid  [csc_pkg::ENTRIES] = '{default: '0};
   logic [csc_pkg::STAMP_W-1:0] tbl_stamp [csc_pkg::ENTRIES] = '{default: '0};
   logic [csc_pkg::STAMP_W-1:0] stamp_ctr = '0;

   cache_req_type pending_reqs[$];
   cache_rsp_type expected_rsps[$];

   logic req_accepted = 1'b0;
   logic rx_hold      = 1'b0;
   int   tx_gap       = 0;
   int   tx_idle_pct  = 0;
   int   rx_gap       = 0;
   int   total_items  = 0;
   int   accepted_cnt = 0;
   int   rsp_count    = 0;
   int   mismatch_cnt = 0;
   int   n_insert     = 0;
   int   n_reuse      = 0;
   int   n_evict      = 0;
   int   n_lookup     = 0;
   int   n_lookup_hit = 0;

   callsign_ssid_cache_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_name          (req_name),
      .req_name_too_long (req_name_too_long),
      .req_suffix_in     (req_suffix_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_ssid_out      (rsp_ssid_out),
      .rsp_slot          (rsp_slot)
   );

   // clock
   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   // text to a zero padded name field, first character in the top byte
   function automatic logic [csc_pkg::NAME_W-1:0] txt(input string s);
      logic [csc_pkg::NAME_W-1:0] v;
      v = '0;
      for (int i = 0; i < csc_pkg::NAME_CHARS; i++) begin
         v = {v[csc_pkg::NAME_W-9:0], (i < s.len()) ? 8'(s[i]) : 8'h00};
      end
      return v;
   endfunction

   task automatic add_req(input logic func, input logic [csc_pkg::NAME_W-1:0] name,
                          input logic too_long, input logic [csc_pkg::SSID_W-1:0] suffix);
      cache_req_type r;
      r.func     = func;
      r.name     = name;
      r.too_long = too_long;
      r.suffix   = suffix;
      pending_reqs.push_back(r);
   endtask

   // apply one request to the table model and work out its result
   task automatic cache_access(input cache_req_type r, output cache_rsp_type e);
      logic [7:0]                 b [csc_pkg::NAME_CHARS];
      logic [csc_pkg::NAME_W-1:0] key;
      int                         len;
      bit                         ended;
      bit                         ok;
      bit                         matched;
      int                         target;
      int                         oldest;
      len   = csc_pkg::NAME_CHARS;
      ended = 1'b0;
      key   = '0;
      e     = '{hit: 1'b0, ssid: '0, slot: '0};
      // a name ends at its first zero byte, the rest reads as zero
      for (int i = 0; i < csc_pkg::NAME_CHARS; i++) begin
         b[i] = r.name[8*(csc_pkg::NAME_CHARS-1-i) +: 8];
         if (ended || b[i] == 8'h00) begin
            if (!ended) len = i;
            ended = 1'b1;
            b[i]  = 8'h00;
         end
      end
      if (r.func == csc_pkg::FUNC_INSERT) begin
         n_insert++;
         for (int i = 0; i < csc_pkg::NAME_CHARS; i++) key = {key[csc_pkg::NAME_W-9:0], b[i]};
         target  = -1;
         oldest  = 0;
         matched = 1'b0;
         // exact match first, else first empty, else first oldest stamp
         for (int i = 0; i < csc_pkg::ENTRIES; i++) begin
            if (tbl_name[i] == key) begin
               target  = i;
               matched = 1'b1;
               break;
            end
            if (tbl_name[i] == '0 && target < 0) target = i;
            if (tbl_stamp[i] < tbl_stamp[oldest]) oldest = i;
         end
         if (target < 0) begin
            target = oldest;
            n_evict++;
         end
         if (matched) n_reuse++;
         stamp_ctr         = stamp_ctr + 1'b1;
         tbl_name[target]  = key;
         tbl_ssid[target]  = r.suffix;
         tbl_stamp[target] = stamp_ctr;
         e.hit  = matched;
         e.slot = csc_pkg::SLOT_W'(target);
      end else begin
         n_lookup++;
         ok = (len != 0) && !r.too_long;
         // alphanumeric only, lowercase folded
         for (int i = 0; i < len; i++) begin
            if (!((b[i] >= "0" && b[i] <= "9") || (b[i] >= "A" && b[i] <= "Z") ||
                  (b[i] >= "a" && b[i] <= "z"))) begin
               ok = 1'b0;
            end else if (b[i] >= "a" && b[i] <= "z") begin
               b[i] = b[i] - 8'd32;
            end
         end
         if (ok) begin
            for (int i = 0; i < csc_pkg::NAME_CHARS; i++) key = {key[csc_pkg::NAME_W-9:0], b[i]};
            for (int i = 0; i < csc_pkg::ENTRIES; i++) begin
               if (tbl_name[i] == key) begin
                  e.hit  = 1'b1;
                  e.ssid = tbl_ssid[i];
                  e.slot = csc_pkg::SLOT_W'(i);
                  n_lookup_hit++;
                  break;
               end
            end
         end
      end
   endtask

   // request driver, changes at the falling edge
   always @(negedge clock) begin
      cache_req_type cur;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (tx_gap > 0) begin
            tx_gap = tx_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > QUIET_ITEMS &&
                      $urandom_range(0, 99) < tx_idle_pct) begin
            tx_gap = $urandom_range(0, 4);
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            cur = pending_reqs.pop_front();
            req_func          <= cur.func;
            req_name          <= cur.name;
            req_name_too_long <= cur.too_long;
            req_suffix_in     <= cur.suffix;
            req_valid         <= 1'b1;
            // idle density before the next request: none, sparse or long chains
            case ($urandom_range(0, 2))
               0: tx_idle_pct = 0;
               1: tx_idle_pct = 15;
               default: tx_idle_pct = 98;
            endcase
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver with random stall bursts
   always @(negedge clock) begin
      if (reset || rx_hold) begin
         rsp_ready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap = rx_gap - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_count < total_items - QUIET_ITEMS && $urandom_range(0, 5) == 0) begin
         rx_gap = $urandom_range(0, 4);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // long receiver hold-off so the block fills and stalls its input
   initial begin
      while (reset || rsp_count < 150) @(negedge clock);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      rx_hold <= 1'b0;
   end

   // monitor: predict on request acceptance, check on result acceptance
   always @(posedge clock) begin
      cache_req_type acc;
      cache_rsp_type exp_rsp;
      req_accepted <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         acc.func     = req_func;
         acc.name     = req_name;
         acc.too_long = req_name_too_long;
         acc.suffix   = req_suffix_in;
         cache_access(acc, exp_rsp);
         expected_rsps.push_back(exp_rsp);
         accepted_cnt++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
               $display("unexpected result %0d: hit=%0d ssid=%02h slot=%0d",
                        rsp_count, rsp_hit, rsp_ssid_out, rsp_slot);
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_hit !== exp_rsp.hit || rsp_ssid_out !== exp_rsp.ssid ||
                rsp_slot !== exp_rsp.slot) begin
               mismatch_cnt++;
               if (mismatch_cnt <= MAX_REPORTS)
                  $display({"result %0d mismatch: expected hit=%0d ssid=%02h slot=%0d, ",
                            "got hit=%0d ssid=%02h slot=%0d"},
                           rsp_count, exp_rsp.hit, exp_rsp.ssid, exp_rsp.slot,
                           rsp_hit, rsp_ssid_out, rsp_slot);
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic [csc_pkg::NAME_W-1:0] call_pool [POOL_SIZE];
      logic [csc_pkg::NAME_W-1:0] nm;
      logic [7:0]                 c;
      int                         len;
      int                         pick;
      int                         pos;

      // directed: empty table, folding, reuse, truncation, empty name, odd bytes
      add_req(csc_pkg::FUNC_LOOKUP, txt("A"), 1'b0, 8'h00);
      add_req(csc_pkg::FUNC_INSERT, txt("N0CALL"), 1'b0, 8'hFF);
      add_req(csc_pkg::FUNC_LOOKUP, txt("n0call"), 1'b0, 8'h00);
      add_req(csc_pkg::FUNC_LOOKUP, txt("N0CALL"), 1'b1, 8'h00);
      add_req(csc_pkg::FUNC_INSERT, txt("N0CALL"), 1'b0, 8'h07);
      add_req(csc_pkg::FUNC_INSERT, txt("ABCDEF"), 1'b1, 8'h00);
      add_req(csc_pkg::FUNC_LOOKUP, txt("ABCDEF"), 1'b0, 8'hFF);
      add_req(csc_pkg::FUNC_INSERT, {"AB", 8'h00, "XYZ"}, 1'b0, 8'h5A);
      add_req(csc_pkg::FUNC_LOOKUP, {"ab", 8'h00, "Q", 16'h0000}, 1'b0, 8'h00);
      add_req(csc_pkg::FUNC_LOOKUP, '0, 1'b0, 8'h00);
      add_req(csc_pkg::FUNC_INSERT, '0, 1'b0, 8'h33);
      add_req(csc_pkg::FUNC_INSERT, txt("Z"), 1'b0, 8'h11);
      add_req(csc_pkg::FUNC_INSERT, txt("abc"), 1'b0, 8'h22);
      add_req(csc_pkg::FUNC_LOOKUP, txt("abc"), 1'b0, 8'h00);
      add_req(csc_pkg::FUNC_INSERT, txt("A-1"), 1'b0, 8'h44);
      add_req(csc_pkg::FUNC_LOOKUP, txt("A-1"), 1'b0, 8'h00);
      add_req(csc_pkg::FUNC_INSERT, '1, 1'b1, 8'hFF);
      add_req(csc_pkg::FUNC_LOOKUP, '1, 1'b0, 8'h00);
      add_req(csc_pkg::FUNC_INSERT, txt("09AZ"), 1'b0, 8'h80);
      add_req(csc_pkg::FUNC_LOOKUP, txt("09az"), 1'b0, 8'h00);
      add_req(csc_pkg::FUNC_LOOKUP, {"/:@[", 8'h60, "{"}, 1'b0, 8'h00);
      add_req(csc_pkg::FUNC_LOOKUP, txt("Z9Z9Z9"), 1'b0, 8'h00);
      add_req(csc_pkg::FUNC_INSERT, txt("Z9Z9Z9"), 1'b0, 8'h01);
      add_req(csc_pkg::FUNC_LOOKUP, txt("z9z9z9"), 1'b0, 8'h00);
      add_req(csc_pkg::FUNC_LOOKUP, {"A", 8'h80, 32'h0}, 1'b0, 8'h00);

      // pool of well-formed uppercase names, larger than the table
      for (int i = 0; i < POOL_SIZE; i++) begin
         len = $urandom_range(1, csc_pkg::NAME_CHARS);
         nm  = '0;
         for (int k = 0; k < csc_pkg::NAME_CHARS; k++) begin
            pick = $urandom_range(0, 35);
            c    = (pick < 10) ? 8'("0") + 8'(pick) : 8'("A") + 8'(pick - 10);
            nm   = {nm[csc_pkg::NAME_W-9:0], (k < len) ? c : 8'h00};
         end
         call_pool[i] = nm;
      end

      // random: mostly pool inserts and lookups, some noise
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         nm   = call_pool[$urandom_range(0, POOL_SIZE - 1)];
         if (pick < 45) begin
            add_req(csc_pkg::FUNC_INSERT, nm, $urandom_range(0, 9) == 0,
                    8'($urandom_range(0, 255)));
         end else if (pick < 85) begin
            // random case mix, sometimes one corrupted byte
            for (int k = 0; k < csc_pkg::NAME_CHARS; k++) begin
               c = nm[8*k +: 8];
               if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) nm[8*k +: 8] = c + 8'd32;
            end
            if ($urandom_range(0, 9) == 0) begin
               pos = $urandom_range(0, csc_pkg::NAME_CHARS - 1);
               nm[8*pos +: 8] = 8'($urandom_range(0, 255));
            end
            add_req(csc_pkg::FUNC_LOOKUP, nm, $urandom_range(0, 19) == 0,
                    8'($urandom_range(0, 255)));
         end else begin
            nm = {16'($urandom), 32'($urandom)};
            if ($urandom_range(0, 2) == 0) begin
               pos = $urandom_range(0, csc_pkg::NAME_CHARS - 1);
               nm[8*pos +: 8] = 8'h00;
            end
            add_req($urandom_range(0, 1) ? csc_pkg::FUNC_LOOKUP : csc_pkg::FUNC_INSERT, nm,
                    1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end
      end
      total_items = pending_reqs.size();

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      while (accepted_cnt < total_items) @(negedge clock);
      while (expected_rsps.size() > 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d requests: %0d inserts (%0d reused, %0d evicted oldest)",
               accepted_cnt, n_insert, n_reuse, n_evict);
      $display("%0d lookups with %0d hits, %0d results checked, %0d mismatches",
               n_lookup, n_lookup_hit, rsp_count, mismatch_cnt);
      if (mismatch_cnt == 0 && expected_rsps.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // run limit
   initial begin
      #(CLK_PERIOD * LIMIT_CYCLES);
      $display("timeout: %0d of %0d requests accepted, %0d results pending",
               accepted_cnt, total_items, expected_rsps.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
